// File: hw/rtl/rstab_pkg.sv
// rstab_pkg: shared constants, codes and control structs for the request slot table.
// Used by rstab_ctrl, rstab_dpath and request_slot_table_core; depends on nothing.
`default_nettype none
package rstab_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int LIMIT_W  = 5;
	localparam int CMD_W    = 2;
	localparam int ID_W     = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	// Command codes; the unused code behaves as a plain lookup
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DROP   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISS      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_DROP_MISS = 3'd5;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} dp_stat_t;

	// Low bits of a slot number as carried on the result beat
	function automatic logic [SLOT_W-1:0] slot_out(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide[SLOT_W-1:0];
	endfunction

	// Usable slots for lookups and creates: the limit when it is nonzero and below the depth
	function automatic logic [CNT_W-1:0] scan_cap(input logic [LIMIT_W-1:0] limit);
		logic [CNT_W-1:0] cap;
		cap = CNT_W'(TABLE_DEPTH);
		if (limit != '0 && 32'(limit) < 32'(TABLE_DEPTH)) begin
			cap = CNT_W'(limit);
		end
		return cap;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rstab_ctrl.sv
// rstab_ctrl: sequencer for the request slot table: accept, scan, finish.
// Depends on rstab_pkg; drives rstab_dpath through dp_cmd_t and reads dp_stat_t.
`default_nettype none
module rstab_ctrl
	import rstab_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.done) begin
					cmd.step = 1'b1;
				end else if (stat.out_free) begin
					// hold the scan at its final slot until the result register drains
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE)
		else $error("load issued outside idle");

	a_finish_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (stat.done && stat.out_free))
		else $error("finish without a free result register");

	a_scan_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !stat.done) |=> state_q == S_SCAN)
		else $error("scan left before completion");

endmodule
`default_nettype wire

// File: hw/rtl/rstab_dpath.sv
// rstab_dpath: slot storage, scan counter, one identifier comparator and result register.
// Depends on rstab_pkg; sequenced by rstab_ctrl.
`default_nettype none
module rstab_dpath
	import rstab_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,
	input  wire logic                 cfg_we,
	input  wire logic   [LIMIT_W-1:0] cfg_wdata,
	input  wire dp_cmd_t              cmd,
	output dp_stat_t                  stat
);

	logic [LIMIT_W-1:0]     limit_q;
	logic [CMD_W-1:0]       cmd_q;
	logic [ID_W-1:0]        id_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       free_q;
	logic                   have_free_q;
	logic [TABLE_DEPTH-1:0] slot_valid_q;
	logic [ID_W-1:0]        slot_ident_q [TABLE_DEPTH];
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [SLOT_W-1:0]      out_slot_q;

	logic                   is_drop;
	logic [CNT_W-1:0]       scan_end;
	logic                   cur_valid;
	logic                   hit;
	logic                   last;
	logic                   free_any;
	logic [IDX_W-1:0]       free_idx;
	logic                   do_create;
	logic [STATUS_W-1:0]    res_status;
	logic [SLOT_W-1:0]      res_slot;

	assign is_drop   = (cmd_q == CMD_DROP);
	assign scan_end  = is_drop ? CNT_W'(TABLE_DEPTH) : scan_cap(limit_q);
	assign cur_valid = slot_valid_q[idx_q];
	assign hit       = cur_valid && (slot_ident_q[idx_q] == id_q);
	assign last      = (CNT_W'(idx_q) == (scan_end - CNT_W'(1)));

	// first free slot seen so far, counting the slot under the comparator
	assign free_any = have_free_q || !cur_valid;
	assign free_idx = have_free_q ? free_q : idx_q;

	always_comb begin
		do_create  = 1'b0;
		res_slot   = '0;
		if (is_drop) begin
			res_status = hit ? ST_DROPPED : ST_DROP_MISS;
			if (hit) begin
				res_slot = slot_out(idx_q);
			end
		end else if (hit) begin
			res_status = ST_HIT;
			res_slot   = slot_out(idx_q);
		end else if (cmd_q != CMD_CREATE) begin
			res_status = ST_MISS;
		end else if (free_any) begin
			res_status = ST_CREATED;
			res_slot   = slot_out(free_idx);
			do_create  = 1'b1;
		end else begin
			res_status = ST_FULL;
		end
	end

	assign stat.done     = hit || last;
	assign stat.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= '0;
			idx_q        <= '0;
			have_free_q  <= 1'b0;
			slot_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.load) begin
				idx_q       <= '0;
				have_free_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + IDX_W'(1);
				if (!cur_valid) begin
					have_free_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				if (is_drop && hit) begin
					slot_valid_q[idx_q] <= 1'b0;
				end else if (do_create) begin
					slot_valid_q[free_idx] <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= s_tdata[CMD_W-1:0];
			id_q  <= s_tdata[CMD_W+ID_W-1:CMD_W];
		end
		if (cmd.step && !have_free_q && !cur_valid) begin
			free_q <= idx_q;
		end
		if (cmd.finish) begin
			out_status_q <= res_status;
			out_slot_q   <= res_slot;
			if (do_create) begin
				slot_ident_q[free_idx] <= id_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - STATUS_W - SLOT_W){1'b0}}, out_slot_q, out_status_q};

	a_create_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && do_create) |=> slot_valid_q[$past(free_idx)])
		else $error("created slot not marked valid");

	a_drop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && is_drop && hit) |=> !slot_valid_q[$past(idx_q)])
		else $error("dropped slot still valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !cmd.finish)
		else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

// File: hw/rtl/request_slot_table_core.sv
// request_slot_table_core: top level of the request slot table.
// Depends on rstab_pkg, rstab_ctrl and rstab_dpath.
//
// Usage:
//   Commands arrive as beats on s_tvalid/s_tready/s_tdata; each produces exactly
//   one result beat on m_tvalid/m_tready/m_tdata. cfg_we/cfg_wdata write the
//   in-flight limit; write it only while no command is in progress.
//   A lookup or create scans slots 0..cap-1, a drop scans all 16 slots, with one
//   identifier comparator visiting one slot per cycle. A command visits slots up
//   to the first match or the end of its range; the result is registered when
//   the scan ends, and the next beat is taken only once the block is back idle,
//   so a new command is not accepted before the last one is finished.
//   s_tready is high only while no command is being scanned. A finished result
//   waits in the output register; the next command is accepted and scanned
//   meanwhile, and its last scan step holds until the output register drains.
//   Reset clears all valid marks, the limit and the output valid flag at once;
//   there is no clearing pass.
`default_nettype none
module request_slot_table_core
	import rstab_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // [1:0] cmd, [33:2] request_id, rest zero
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,   // [2:0] status, [6:3] slot_index, [7] zero
	input  wire logic                 cfg_we,
	input  wire logic   [LIMIT_W-1:0] cfg_wdata  // inflight_limit
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	rstab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	rstab_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

endmodule
`default_nettype wire

// File: verif/tb_request_slot_table_core.sv
`timescale 1ns / 1ps
// tb_request_slot_table_core: self-checking testbench for the request slot table.
// Predicts every result beat from its own copy of the table and limit, with random gaps on both
// stream sides except in steady phases; depends on rstab_pkg and request_slot_table_core.
module tb_request_slot_table_core;
	import rstab_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // unused code, acts as a lookup
	localparam int MAX_GAP = 13;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int POOL_SIZE = 20;
	localparam int PHASE_ITEMS = 62;

	// id above cmd so that cmd lands in the low bits of tdata
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [CMD_W-1:0] cmd;
	} cmd_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
	} slot_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // [1:0] cmd, [33:2] request_id, rest zero
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // [2:0] status, [6:3] slot_index, [7] zero
	logic                 cfg_we = 1'b0;
	logic [LIMIT_W-1:0]   cfg_wdata = '0;

	// Predicted table state
	bit                 tab_valid [TABLE_DEPTH];
	logic [ID_W-1:0]    tab_ident [TABLE_DEPTH];
	logic [LIMIT_W-1:0] tab_limit = '0;

	cmd_beat_t    cmd_backlog[$];
	slot_result_t expected_results[$];
	logic [ID_W-1:0] id_pool [POOL_SIZE];

	bit in_fire = 1'b0;
	bit out_fire = 1'b0;
	bit steady = 1'b0;
	int send_gap = 0;
	int drain_stall = 0;
	int idle_cycles = 0;
	int error_count = 0;
	int beats_in = 0;
	int beats_out = 0;
	int phases = 0;
	int status_seen [6];

	request_slot_table_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic int pick_delay();
		return steady ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Apply one command to the predicted table and return the result it produces
	function automatic slot_result_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [ID_W-1:0] id);
		slot_result_t r;
		int cap;
		int free_at;
		int i;
		bit done;
		r.status = ST_MISS;
		r.slot = '0;
		free_at = -1;
		done = 1'b0;
		if (cmd == CMD_DROP) begin
			// drop ignores the cap and searches every slot
			r.status = ST_DROP_MISS;
			for (i = 0; i < TABLE_DEPTH && !done; i++) begin
				if (tab_valid[i] && tab_ident[i] == id) begin
					tab_valid[i] = 1'b0;
					r.status = ST_DROPPED;
					r.slot = SLOT_W'(i);
					done = 1'b1;
				end
			end
			return r;
		end
		cap = (tab_limit != 0 && int'(tab_limit) < TABLE_DEPTH) ? int'(tab_limit) : TABLE_DEPTH;
		for (i = 0; i < cap && !done; i++) begin
			if (tab_valid[i]) begin
				if (tab_ident[i] == id) begin
					r.status = ST_HIT;
					r.slot = SLOT_W'(i);
					done = 1'b1;
				end
			end else if (free_at < 0) begin
				free_at = i;
			end
		end
		if (!done && cmd == CMD_CREATE) begin
			if (free_at < 0) begin
				r.status = ST_FULL;
			end else begin
				tab_valid[free_at] = 1'b1;
				tab_ident[free_at] = id;
				r.status = ST_CREATED;
				r.slot = SLOT_W'(free_at);
			end
		end
		return r;
	endfunction

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
		cmd_beat_t b;
		b.cmd = cmd;
		b.id = id;
		cmd_backlog.push_back(b);
	endtask

	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || s_tvalid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	// Write a new limit on an idle block, then queue a random mix around a small id pool
	task automatic run_phase(input logic [LIMIT_W-1:0] limit);
		int k;
		int r;
		logic [ID_W-1:0] id;
		wait_drained();
		steady = (phases % 3 == 2);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= limit;
		tab_limit = limit;
		@(negedge clk);
		cfg_we <= 1'b0;
		phases++;
		for (k = 12; k < POOL_SIZE; k++) begin
			id_pool[k] = $urandom;
		end
		for (k = 0; k < PHASE_ITEMS; k++) begin
			r = $urandom_range(0, 99);
			id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
				: ID_W'($urandom);
			if (r < 38) begin
				queue_cmd(CMD_CREATE, id);
			end else if (r < 62) begin
				queue_cmd(CMD_LOOKUP, id);
			end else if (r < 95) begin
				queue_cmd(CMD_DROP, id);
			end else begin
				queue_cmd(CMD_SPARE, id);
			end
		end
	endtask

	// Command side: hold each beat until taken, then sit out a random gap
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (in_fire) begin
				send_gap = pick_delay();
			end
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= S_TDATA_W'(cmd_backlog.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result side: stall a random number of cycles after each taken beat
	always @(negedge clk) begin
		if (arst_n && (!m_tready || out_fire)) begin
			if (out_fire) begin
				drain_stall = pick_delay();
			end
			if (drain_stall > 0) begin
				drain_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		slot_result_t want;
		slot_result_t got;
		in_fire = arst_n && s_tvalid && s_tready;
		out_fire = arst_n && m_tvalid && m_tready;
		if (in_fire) begin
			expected_results.push_back(apply_command(s_tdata[CMD_W-1:0],
				s_tdata[CMD_W+ID_W-1:CMD_W]));
			beats_in++;
		end
		if (out_fire) begin
			got.status = m_tdata[STATUS_W-1:0];
			got.slot = m_tdata[STATUS_W+SLOT_W-1:STATUS_W];
			beats_out++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing pending: status %0d slot %0d",
					got.status, got.slot));
			end else begin
				want = expected_results.pop_front();
				status_seen[want.status]++;
				if (got.status !== want.status) begin
					report_mismatch($sformatf("result %0d status %0d, want %0d",
						beats_out, got.status, want.status));
				end
				if (got.slot !== want.slot) begin
					report_mismatch($sformatf("result %0d slot_index %0d, want %0d",
						beats_out, got.slot, want.slot));
				end
			end
		end
		if (in_fire || out_fire || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int k;
		for (k = 0; k < TABLE_DEPTH; k++) begin
			tab_valid[k] = 1'b0;
			tab_ident[k] = '0;
		end
		for (k = 0; k < POOL_SIZE; k++) begin
			id_pool[k] = $urandom;
		end
		id_pool[0] = '0;
		id_pool[1] = '1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, both id extremes, spare code, drop twice, slot reuse, full
		queue_cmd(CMD_LOOKUP, '0);
		queue_cmd(CMD_CREATE, '0);
		queue_cmd(CMD_CREATE, '1);
		queue_cmd(CMD_LOOKUP, '1);
		queue_cmd(CMD_SPARE, '1);
		queue_cmd(CMD_SPARE, 32'h0000_1234);
		queue_cmd(CMD_DROP, '0);
		queue_cmd(CMD_DROP, '0);
		queue_cmd(CMD_CREATE, 32'hA5A5_A5A5);
		for (k = 0; k < TABLE_DEPTH - 2; k++) begin
			queue_cmd(CMD_CREATE, id_pool[k + 2]);
		end
		queue_cmd(CMD_CREATE, 32'h5A5A_5A5A);
		queue_cmd(CMD_LOOKUP, '1);

		// Limits: smallest cap, above depth, depth minus one, exactly depth, mid, zero, random
		run_phase(5'd1);
		run_phase(5'd31);
		run_phase(5'd15);
		run_phase(5'd16);
		run_phase(5'd5);
		run_phase(5'd0);
		run_phase(LIMIT_W'($urandom_range(0, 31)));

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Ran %0d commands and checked %0d results over %0d limit settings.",
			beats_in, beats_out, phases + 1);
		$display("Outcomes: %0d hit, %0d created, %0d miss, %0d full, %0d dropped, %0d drop miss.",
			status_seen[ST_HIT], status_seen[ST_CREATED], status_seen[ST_MISS],
			status_seen[ST_FULL], status_seen[ST_DROPPED], status_seen[ST_DROP_MISS]);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			if (expected_results.size() != 0) begin
				report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
			end
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/rstab_pkg.sv
hw/rtl/rstab_ctrl.sv
hw/rtl/rstab_dpath.sv
hw/rtl/request_slot_table_core.sv
verif/tb_request_slot_table_core.sv
